/* src/cmfts_pkg.sv */
// Shared widths, codes, types and helpers of the cube map face texel select block.
`timescale 1ns / 1ps

package cmfts_pkg;

  localparam int DIR_W         = 16;
  localparam int FACE_W        = 3;
  localparam int COORD_W       = 12;
  localparam int SIZE_W        = 13;
  localparam int MAG_W         = 17;
  localparam int NUM_W         = 30;
  localparam int Q_W           = 13;
  localparam int DIV_STAGES    = Q_W;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int MAX_FACE_SIZE = 4096;

  localparam logic [SIZE_W-1:0] FACE_SIZE_RST = SIZE_W'(512);

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } cmfts_face_e;

  typedef enum logic [0:0] {
    REG_FACE_SIZE = 1'b0
  } cmfts_reg_e;

  typedef struct packed {
    cmfts_face_e         face;
    logic                inv;
    logic [SIZE_W-1:0]   size;
  } cmfts_side_t;

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] fs);
    logic [SIZE_W-1:0] r;
    r = fs;
    if (fs == '0) begin
      r = SIZE_W'(1);
    end else if (fs > SIZE_W'(MAX_FACE_SIZE)) begin
      r = SIZE_W'(MAX_FACE_SIZE);
    end
    return r;
  endfunction

endpackage

/* src/cmfts_in_if.sv */
// Direction input channel: valid/ready handshake with three signed components.
`timescale 1ns / 1ps

interface cmfts_in_if import cmfts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

/* src/cmfts_out_if.sv */
// Result output channel: valid/ready handshake with face, texel address and invalid flag.
`timescale 1ns / 1ps

interface cmfts_out_if import cmfts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FACE_W-1:0]  face_index;
  logic [COORD_W-1:0] texel_col;
  logic [COORD_W-1:0] texel_row;
  logic               invalid;

  modport source (output valid, output face_index, output texel_col, output texel_row,
                  output invalid, input ready);
  modport sink   (input valid, input face_index, input texel_col, input texel_row,
                  input invalid, output ready);
endinterface

/* src/cmfts_div.sv */
// Pipelined restoring divider, one quotient bit per stage, MSB first.
`timescale 1ns / 1ps

module cmfts_div import cmfts_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [MAG_W-1:0]      den_i,
  output logic [Q_W-1:0]        quo_o
);

  logic [NUM_W-1:0] rem_q [DIV_STAGES-1];
  logic [MAG_W-1:0] den_q [DIV_STAGES-1];
  logic [Q_W-1:0]   quo_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] dsh;
    logic [MAG_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign dsh  = NUM_W'(den_in) << (DIV_STAGES - 1 - j);
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        quo_q[j] <= {quo_in[Q_W-2:0], take};
      end
    end

    if (j < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          rem_q[j] <= take ? (rem_in - dsh) : rem_in;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

/* src/cube_map_face_texel_select_top.sv */
// Top level: cube map face selection and texel address pipeline with APB config port.
`timescale 1ns / 1ps

// Takes one direction vector per cycle, unless the output stalls, and returns the cube face
// it points at plus the texel column and row on that face. A beat passes the input register,
// major axis and face select, multiply by face size, thirteen divider stages (one quotient
// bit per stage for column and row in parallel), and the clamping output register. Throughput
// is one beat per cycle while the output accepts; each stage holds its beat independently, so
// the pipeline keeps filling while the output is stalled. face_size (address 0) may only be
// written while no beat is in flight; values of 0 act as 1 and values above 4096 act as 4096.
// An all-zero vector returns invalid with zero fields.

module cube_map_face_texel_select_top import cmfts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  cmfts_in_if.sink            dir_i,
  cmfts_out_if.source         res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int NSTG   = DIV_STAGES + 4;
  localparam int DIV_LO = 3;
  localparam int OUT_ST = NSTG - 1;

  // config register
  logic [SIZE_W-1:0] face_size_q;
  logic [SIZE_W-1:0] size_eff;
  cmfts_reg_e        reg_sel;

  assign pready   = 1'b1;
  assign reg_sel  = cmfts_reg_e'(paddr[2]);
  assign size_eff = sat_size(face_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q <= FACE_SIZE_RST;
    end else if (psel && penable && pwrite && (reg_sel == REG_FACE_SIZE)) begin
      face_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FACE_SIZE: prdata = PDATA_W'(face_size_q);
      default:       prdata = '0;
    endcase
  end

  // stage control
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[OUT_ST] = !v_q[OUT_ST] || res_o.ready;
    for (int k = OUT_ST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= dir_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign dir_i.ready = en[0];

  // stage 0: capture and magnitudes
  logic signed [DIR_W-1:0] d0_q [3];
  logic [DIR_W-1:0]        a0_q [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d0_q[0] <= dir_i.dir_x;
      d0_q[1] <= dir_i.dir_y;
      d0_q[2] <= dir_i.dir_z;
      a0_q[0] <= dir_i.dir_x[DIR_W-1] ? DIR_W'(-dir_i.dir_x) : dir_i.dir_x;
      a0_q[1] <= dir_i.dir_y[DIR_W-1] ? DIR_W'(-dir_i.dir_y) : dir_i.dir_y;
      a0_q[2] <= dir_i.dir_z[DIR_W-1] ? DIR_W'(-dir_i.dir_z) : dir_i.dir_z;
    end
  end

  // stage 1: major axis, face, sc/tc offsets
  cmfts_face_e              face1_d, face1_q;
  logic                     inv1_q;
  logic [DIR_W-1:0]         ama;
  logic signed [MAG_W-1:0]  dx, dy, dz, sc, tc;
  logic signed [MAG_W:0]    nsc, ntc, ama_s;
  logic [MAG_W-1:0]         nsc1_q, ntc1_q, den1_q;
  logic [SIZE_W-1:0]        s1_q;

  assign dx = MAG_W'(d0_q[0]);
  assign dy = MAG_W'(d0_q[1]);
  assign dz = MAG_W'(d0_q[2]);

  always_comb begin
    if (a0_q[1] > a0_q[0]) begin
      if (a0_q[2] > a0_q[1]) begin
        ama     = a0_q[2];
        face1_d = (d0_q[2] > 0) ? FACE_POS_Z : FACE_NEG_Z;
      end else begin
        ama     = a0_q[1];
        face1_d = (d0_q[1] > 0) ? FACE_POS_Y : FACE_NEG_Y;
      end
    end else if (a0_q[2] > a0_q[0]) begin
      ama     = a0_q[2];
      face1_d = (d0_q[2] > 0) ? FACE_POS_Z : FACE_NEG_Z;
    end else begin
      ama     = a0_q[0];
      face1_d = (d0_q[0] > 0) ? FACE_POS_X : FACE_NEG_X;
    end

    case (face1_d)
      FACE_POS_X: begin sc = -dz; tc = -dy; end
      FACE_NEG_X: begin sc = dz;  tc = -dy; end
      FACE_POS_Y: begin sc = dx;  tc = dz;  end
      FACE_NEG_Y: begin sc = dx;  tc = -dz; end
      FACE_POS_Z: begin sc = dx;  tc = -dy; end
      default:    begin sc = -dx; tc = -dy; end
    endcase
  end

  assign ama_s = $signed({2'b00, ama});
  assign nsc   = $signed((MAG_W+1)'(sc)) + ama_s;
  assign ntc   = $signed((MAG_W+1)'(tc)) + ama_s;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      face1_q <= face1_d;
      inv1_q  <= (a0_q[0] == '0) && (a0_q[1] == '0) && (a0_q[2] == '0);
      nsc1_q  <= nsc[MAG_W-1:0];
      ntc1_q  <= ntc[MAG_W-1:0];
      den1_q  <= {ama, 1'b0};
      s1_q    <= size_eff;
    end
  end

  // stage 2: scale by face size
  logic [NUM_W-1:0] numc2_q, numr2_q;
  logic [MAG_W-1:0] den2_q;
  cmfts_side_t      side2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      numc2_q <= NUM_W'(nsc1_q) * NUM_W'(s1_q);
      numr2_q <= NUM_W'(ntc1_q) * NUM_W'(s1_q);
      den2_q  <= den1_q;
      side2_q <= '{face: face1_q, inv: inv1_q, size: s1_q};
    end
  end

  // divider stages
  logic [Q_W-1:0] quo_c, quo_r;
  cmfts_side_t    side_q [DIV_STAGES];

  cmfts_div u_div_col (
    .clk_i (clk_i),
    .en_i  (en[DIV_LO +: DIV_STAGES]),
    .num_i (numc2_q),
    .den_i (den2_q),
    .quo_o (quo_c)
  );

  cmfts_div u_div_row (
    .clk_i (clk_i),
    .en_i  (en[DIV_LO +: DIV_STAGES]),
    .num_i (numr2_q),
    .den_i (den2_q),
    .quo_o (quo_r)
  );

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_side
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[DIV_LO]) begin
          side_q[0] <= side2_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[DIV_LO+j]) begin
          side_q[j] <= side_q[j-1];
        end
      end
    end
  end

  // output stage: clamp at face edge, blank invalid beats
  cmfts_side_t        side_l;
  logic [SIZE_W-1:0]  smax;
  logic [Q_W-1:0]     col_c, row_c;
  logic [FACE_W-1:0]  face_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic               inv_q;

  assign side_l = side_q[DIV_STAGES-1];
  assign smax   = side_l.size - SIZE_W'(1);
  assign col_c  = (quo_c > smax) ? smax : quo_c;
  assign row_c  = (quo_r > smax) ? smax : quo_r;

  always_ff @(posedge clk_i) begin
    if (en[OUT_ST]) begin
      inv_q <= side_l.inv;
      if (side_l.inv) begin
        face_q <= FACE_POS_X;
        col_q  <= '0;
        row_q  <= '0;
      end else begin
        face_q <= side_l.face;
        col_q  <= col_c[COORD_W-1:0];
        row_q  <= row_c[COORD_W-1:0];
      end
    end
  end

  assign res_o.valid      = v_q[OUT_ST];
  assign res_o.face_index = face_q;
  assign res_o.texel_col  = col_q;
  assign res_o.texel_row  = row_q;
  assign res_o.invalid    = inv_q;

  // checks
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.invalid |->
      (res_o.face_index == '0) && (res_o.texel_col == '0) && (res_o.texel_row == '0))
    else $error("invalid beat with nonzero fields");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.invalid |-> (res_o.face_index <= FACE_NEG_Z))
    else $error("face index out of range");

  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |->
      (SIZE_W'(res_o.texel_col) < size_eff) && (SIZE_W'(res_o.texel_row) < size_eff))
    else $error("texel address beyond face size");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_i.valid && dir_i.ready |=> v_q[0])
    else $error("accepted beat not held in first stage");

endmodule
